// File: src/gkld_pkg.sv
// Shared types, constants and the logarithm table of the divergence accumulator.
package gkld_pkg;

  localparam int unsigned LOG_TABLE_ENTRIES = 64;
  localparam int unsigned LOG_IDX_W = $clog2(LOG_TABLE_ENTRIES);
  localparam int unsigned ROM_W = 30;
  localparam int unsigned LOG_W = 35;
  localparam int unsigned DATA_W = 32;
  localparam int unsigned SUM_W = 64;
  localparam logic [ROM_W-1:0] LN2_Q30 = 30'd744261118;

  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC_MODE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_POSITIVE_B_RULE = 1'b1;

  typedef logic [LOG_TABLE_ENTRIES:0][ROM_W-1:0] log_rom_t;

  // Restoring shift-and-subtract quotient, used only while the table is built.
  function automatic longint unsigned udiv(input longint unsigned num,
                                           input longint unsigned den);
    longint unsigned q;
    longint unsigned r;
    q = 0;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      r = {r[62:0], num[i]};
      if (r >= den) begin
        r = r - den;
        q[i] = 1'b1;
      end
    end
    return q;
  endfunction

  // Entry k holds ln(1 + k/N) in Q30, evaluated at elaboration as 2*atanh(z).
  function automatic log_rom_t build_log_rom();
    log_rom_t rom;
    longint unsigned n;
    longint unsigned z;
    longint unsigned z2;
    longint unsigned p;
    longint unsigned acc;
    n = 64'(LOG_TABLE_ENTRIES);
    for (int unsigned k = 0; k <= LOG_TABLE_ENTRIES; k++) begin
      if (k == LOG_TABLE_ENTRIES) begin
        rom[k] = LN2_Q30;
      end else begin
        z = udiv(64'(k) << 30, 2 * n + 64'(k));
        z2 = (z * z) >> 30;
        p = z;
        acc = 0;
        for (int unsigned i = 0; i < 40; i++) begin
          if (p != 0) begin
            acc = acc + udiv(p, 64'(2 * i + 1));
            p = (p * z2) >> 30;
          end
        end
        rom[k] = ROM_W'(2 * acc);
      end
    end
    return rom;
  endfunction

  localparam log_rom_t LOG_ROM = build_log_rom();

  typedef enum logic [1:0] {
    TERM_NONE,
    TERM_LINEAR,
    TERM_FULL
  } term_kind_e;

  typedef struct packed {
    logic [DATA_W-1:0] a;
    logic [DATA_W-1:0] b;
    logic              last;
    logic              sym;
    term_kind_e        kind_ab;
    term_kind_e        kind_ba;
  } item_t;

  typedef enum logic [3:0] {
    B_IDLE,
    B_START,
    B_LOGX,
    B_LOGY,
    B_MUL,
    B_MAG,
    B_TERM,
    B_ACC,
    B_NEXT,
    B_FIN
  } back_state_e;

  typedef enum logic [1:0] {
    L_IDLE,
    L_NORM,
    L_MUL,
    L_SUM
  } log_state_e;

endpackage

// File: src/gkld_front.sv
// Front end: configuration registers, pair classification and the item queue.
module gkld_front (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gkld_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic                               cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [gkld_pkg::DATA_W-1:0]        a_value_i,
  input  logic [gkld_pkg::DATA_W-1:0]        b_value_i,
  input  logic                               last_pair_i,
  output gkld_pkg::item_t                    item_o,
  output logic                               item_valid_o,
  input  logic                               item_pop_i
);

  logic sym_q;
  logic pbr_q;
  gkld_pkg::item_t mem_q [2];
  logic wr_ptr_q;
  logic rd_ptr_q;
  logic [1:0] count_q;
  gkld_pkg::item_t new_item;
  logic push;

  function automatic gkld_pkg::term_kind_e classify(input logic [gkld_pkg::DATA_W-1:0] x,
                                                    input logic [gkld_pkg::DATA_W-1:0] y,
                                                    input logic pbr);
    gkld_pkg::term_kind_e kind;
    if (pbr && y == '0) begin
      kind = gkld_pkg::TERM_NONE;
    end else if (x != '0 && y != '0) begin
      kind = gkld_pkg::TERM_FULL;
    end else begin
      kind = gkld_pkg::TERM_LINEAR;
    end
    return kind;
  endfunction

  always_comb begin
    new_item.a = a_value_i;
    new_item.b = b_value_i;
    new_item.last = last_pair_i;
    new_item.sym = sym_q;
    new_item.kind_ab = classify(a_value_i, b_value_i, pbr_q);
    new_item.kind_ba = sym_q ? classify(b_value_i, a_value_i, pbr_q) : gkld_pkg::TERM_NONE;
  end

  assign in_ready_o = (count_q != 2'd2);
  assign push = in_valid_i & in_ready_o;
  assign item_valid_o = (count_q != 2'd0);
  assign item_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sym_q <= 1'b0;
      pbr_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        gkld_pkg::REG_SYMMETRIC_MODE:  sym_q <= cfg_wdata_i;
        gkld_pkg::REG_POSITIVE_B_RULE: pbr_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (item_pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      count_q <= count_q + 2'(push) - 2'(item_pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_item;
    end
  end

endmodule

// File: src/gkld_log.sv
// Natural logarithm in Q30 of a 32-bit raw value by normalization and table interpolation.
module gkld_log (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [gkld_pkg::DATA_W-1:0]   x_i,
  output logic                          done_o,
  output logic [gkld_pkg::LOG_W-1:0]    result_o
);

  localparam int unsigned IW = gkld_pkg::LOG_IDX_W;

  gkld_pkg::log_state_e state_q, state_d;
  logic [31:0] m_q, m_d;
  logic [4:0] e_q, e_d;
  logic [2:0] step_q, step_d;
  logic [gkld_pkg::LOG_W-1:0] base_q, base_d;
  logic [gkld_pkg::ROM_W-1:0] prod_q, prod_d;
  logic [gkld_pkg::LOG_W-1:0] result_q, result_d;
  logic done_q, done_d;

  logic [4:0] sh;
  logic [IW:0] idx_lo;
  logic [IW:0] idx_hi;
  logic [30:0] frac_r;
  logic [gkld_pkg::ROM_W-1:0] rom_lo;
  logic [gkld_pkg::ROM_W-1:0] rom_hi;
  logic [gkld_pkg::ROM_W-1:0] diff;
  logic [gkld_pkg::ROM_W+30:0] prod_full;

  assign sh = 5'(5'd16 >> step_q);
  assign idx_lo = {1'b0, m_q[30 -: IW]};
  assign idx_hi = idx_lo + 1'b1;
  assign frac_r = {m_q[30-IW:0], {IW{1'b0}}};
  assign rom_lo = gkld_pkg::LOG_ROM[idx_lo];
  assign rom_hi = gkld_pkg::LOG_ROM[idx_hi];
  assign diff = (rom_hi > rom_lo) ? rom_hi - rom_lo : '0;
  assign prod_full = (gkld_pkg::ROM_W + 31)'(diff) * (gkld_pkg::ROM_W + 31)'(frac_r);

  always_comb begin
    state_d = state_q;
    m_d = m_q;
    e_d = e_q;
    step_d = step_q;
    base_d = base_q;
    prod_d = prod_q;
    result_d = result_q;
    done_d = 1'b0;
    case (state_q)
      gkld_pkg::L_IDLE: begin
        if (start_i) begin
          m_d = x_i;
          e_d = 5'd31;
          step_d = 3'd0;
          state_d = gkld_pkg::L_NORM;
        end
      end
      gkld_pkg::L_NORM: begin
        if ((m_q >> (6'd32 - 6'(sh))) == 32'd0) begin
          m_d = m_q << sh;
          e_d = e_q - sh;
        end
        step_d = step_q + 3'd1;
        if (step_q == 3'd4) begin
          state_d = gkld_pkg::L_MUL;
        end
      end
      gkld_pkg::L_MUL: begin
        prod_d = prod_full[gkld_pkg::ROM_W+30:31];
        base_d = gkld_pkg::LOG_W'(e_q) * gkld_pkg::LOG_W'(gkld_pkg::LN2_Q30)
                 + gkld_pkg::LOG_W'(rom_lo);
        state_d = gkld_pkg::L_SUM;
      end
      gkld_pkg::L_SUM: begin
        result_d = base_q + gkld_pkg::LOG_W'(prod_q);
        done_d = 1'b1;
        state_d = gkld_pkg::L_IDLE;
      end
      default: state_d = gkld_pkg::L_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gkld_pkg::L_IDLE;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q <= m_d;
    e_q <= e_d;
    step_q <= step_d;
    base_q <= base_d;
    prod_q <= prod_d;
    result_q <= result_d;
  end

  assign done_o = done_q;
  assign result_o = result_q;

endmodule

// File: src/gkld_back.sv
// Back end: per-direction term evaluation, saturating accumulator and result register.
module gkld_back (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  gkld_pkg::item_t                    item_i,
  input  logic                               item_valid_i,
  output logic                               item_pop_o,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [gkld_pkg::SUM_W-1:0]  divergence_o,
  output logic                               overflowed_o
);

  localparam int unsigned LW = gkld_pkg::LOG_W;
  localparam int unsigned PW = gkld_pkg::LOG_W + 16;
  localparam int unsigned SW = gkld_pkg::SUM_W;

  gkld_pkg::back_state_e state_q, state_d;
  logic dir_q, dir_d;
  logic [31:0] x_q, x_d;
  logic [31:0] y_q, y_d;
  logic [LW-1:0] lx_q, lx_d;
  logic [LW-1:0] d_q, d_d;
  logic neg_q, neg_d;
  logic [PW-1:0] hi_q, hi_d;
  logic [PW-1:0] lo_q, lo_d;
  logic [SW-1:0] mag_q, mag_d;
  logic [SW-1:0] term_q, term_d;
  logic [SW-1:0] sum_q, sum_d;
  logic ovf_q, ovf_d;
  logic out_valid_q, out_valid_d;
  logic [SW-1:0] out_div_q, out_div_d;
  logic out_ovf_q, out_ovf_d;

  gkld_pkg::term_kind_e kind;
  logic log_start;
  logic [31:0] log_x;
  logic log_done;
  logic [LW-1:0] log_res;
  logic [PW:0] mid;
  logic [SW:0] sum_ext;

  gkld_log u_log (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (log_start),
    .x_i      (log_x),
    .done_o   (log_done),
    .result_o (log_res)
  );

  assign kind = dir_q ? item_i.kind_ba : item_i.kind_ab;
  assign mid = (PW + 1)'({hi_q[13:0], 16'h0000}) + (PW + 1)'(lo_q);
  assign sum_ext = {sum_q[SW-1], sum_q} + {term_q[SW-1], term_q};

  always_comb begin
    state_d = state_q;
    dir_d = dir_q;
    x_d = x_q;
    y_d = y_q;
    lx_d = lx_q;
    d_d = d_q;
    neg_d = neg_q;
    hi_d = hi_q;
    lo_d = lo_q;
    mag_d = mag_q;
    term_d = term_q;
    sum_d = sum_q;
    ovf_d = ovf_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_div_d = out_div_q;
    out_ovf_d = out_ovf_q;
    log_start = 1'b0;
    log_x = x_q;
    item_pop_o = 1'b0;
    case (state_q)
      gkld_pkg::B_IDLE: begin
        if (item_valid_i) begin
          dir_d = 1'b0;
          state_d = gkld_pkg::B_START;
        end
      end
      gkld_pkg::B_START: begin
        x_d = dir_q ? item_i.b : item_i.a;
        y_d = dir_q ? item_i.a : item_i.b;
        case (kind)
          gkld_pkg::TERM_FULL: begin
            log_start = 1'b1;
            log_x = dir_q ? item_i.b : item_i.a;
            state_d = gkld_pkg::B_LOGX;
          end
          gkld_pkg::TERM_LINEAR: begin
            mag_d = '0;
            neg_d = 1'b0;
            state_d = gkld_pkg::B_TERM;
          end
          default: state_d = gkld_pkg::B_NEXT;
        endcase
      end
      gkld_pkg::B_LOGX: begin
        if (log_done) begin
          lx_d = log_res;
          log_start = 1'b1;
          log_x = y_q;
          state_d = gkld_pkg::B_LOGY;
        end
      end
      gkld_pkg::B_LOGY: begin
        if (log_done) begin
          neg_d = lx_q < log_res;
          d_d = (lx_q < log_res) ? log_res - lx_q : lx_q - log_res;
          state_d = gkld_pkg::B_MUL;
        end
      end
      gkld_pkg::B_MUL: begin
        hi_d = PW'(d_q) * PW'(x_q[31:16]);
        lo_d = PW'(d_q) * PW'(x_q[15:0]);
        state_d = gkld_pkg::B_MAG;
      end
      gkld_pkg::B_MAG: begin
        mag_d = SW'(hi_q >> 14) + SW'(mid >> 30);
        state_d = gkld_pkg::B_TERM;
      end
      gkld_pkg::B_TERM: begin
        term_d = (neg_q ? -mag_q : mag_q) + {32'h0, y_q} - {32'h0, x_q};
        state_d = gkld_pkg::B_ACC;
      end
      gkld_pkg::B_ACC: begin
        if (sum_ext[SW] != sum_ext[SW-1]) begin
          sum_d = sum_ext[SW] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};
          ovf_d = 1'b1;
        end else begin
          sum_d = sum_ext[SW-1:0];
        end
        state_d = gkld_pkg::B_NEXT;
      end
      gkld_pkg::B_NEXT: begin
        if (!dir_q && item_i.sym) begin
          dir_d = 1'b1;
          state_d = gkld_pkg::B_START;
        end else if (item_i.last) begin
          state_d = gkld_pkg::B_FIN;
        end else begin
          item_pop_o = 1'b1;
          state_d = gkld_pkg::B_IDLE;
        end
      end
      gkld_pkg::B_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_div_d = item_i.sym ? {sum_q[SW-1], sum_q[SW-1:1]} : sum_q;
          out_ovf_d = ovf_q;
          sum_d = '0;
          ovf_d = 1'b0;
          item_pop_o = 1'b1;
          state_d = gkld_pkg::B_IDLE;
        end
      end
      default: state_d = gkld_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= gkld_pkg::B_IDLE;
      dir_q <= 1'b0;
      sum_q <= '0;
      ovf_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      dir_q <= dir_d;
      sum_q <= sum_d;
      ovf_q <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    lx_q <= lx_d;
    d_q <= d_d;
    neg_q <= neg_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
    mag_q <= mag_d;
    term_q <= term_d;
    out_div_q <= out_div_d;
    out_ovf_q <= out_ovf_d;
  end

  assign out_valid_o = out_valid_q;
  assign divergence_o = out_div_q;
  assign overflowed_o = out_ovf_q;

`ifndef SYNTHESIS
  a_fin_loads_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gkld_pkg::B_FIN && (!out_valid_q || out_ready_i)) |=> out_valid_q)
    else $error("finished run did not load the result register");

  a_fin_clears_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == gkld_pkg::B_FIN && (!out_valid_q || out_ready_i)) |=> (sum_q == '0 && !ovf_q))
    else $error("accumulator not cleared after a result");

  a_no_stray_log_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    log_done |-> (state_q == gkld_pkg::B_LOGX || state_q == gkld_pkg::B_LOGY))
    else $error("logarithm finished outside a logarithm wait");
`endif

endmodule

// File: src/generalized_kl_divergence_top.sv
// Top level of the generalized Kullback-Leibler divergence accumulator.
// Each accepted beat is one element pair; the back end picks up the pair and then
// works through each direction: a term that needs a logarithm runs the logarithm
// unit twice, a linear-only term skips it, and a direction with no term adds nothing,
// and symmetric mode runs both directions; the last pair of a run also loads the result
// register, and first waits while the previous result still waits to be taken.
// The work per pair is set by the single shared logarithm unit, which runs twice
// per logarithm direction (5 normalization steps, a table lookup with multiply, a sum).
// A two-beat queue lets the input side take pairs while the back end works, and the
// result register holds the sum after the last pair while the next run starts.
module generalized_kl_divergence_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [gkld_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic                               cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [31:0]                        a_value_i,
  input  logic [31:0]                        b_value_i,
  input  logic                               last_pair_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [63:0]                 divergence_o,
  output logic                               overflowed_o
);

  gkld_pkg::item_t item;
  logic item_valid;
  logic item_pop;

  gkld_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .a_value_i    (a_value_i),
    .b_value_i    (b_value_i),
    .last_pair_i  (last_pair_i),
    .item_o       (item),
    .item_valid_o (item_valid),
    .item_pop_i   (item_pop)
  );

  gkld_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_i       (item),
    .item_valid_i (item_valid),
    .item_pop_o   (item_pop),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .divergence_o (divergence_o),
    .overflowed_o (overflowed_o)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the generalized Kullback-Leibler divergence accumulator.

class divergence_scoreboard;
  typedef struct {
    logic signed [63:0] divergence;
    logic               overflowed;
  } sum_result_t;

  localparam longint unsigned LN2_FIX = 64'd744261118;
  localparam int unsigned SEGMENTS = 64;

  longint unsigned    ln_table [SEGMENTS+1];
  bit                 sym_mode;
  bit                 b_rule;
  logic signed [63:0] run_sum;
  bit                 sat_seen;
  sum_result_t        pending_sums [$];
  int                 errors;
  int                 pairs_seen;
  int                 sums_checked;

  function new();
    longint unsigned z, z2, p, acc;
    for (int k = 0; k <= SEGMENTS; k++) begin
      if (k == SEGMENTS) begin
        ln_table[k] = LN2_FIX;
      end else begin
        z = (longint'(k) << 30) / (2 * SEGMENTS + k);
        z2 = (z * z) >> 30;
        p = z;
        acc = 0;
        for (int i = 0; i < 40 && p != 0; i++) begin
          acc += p / (2 * i + 1);
          p = (p * z2) >> 30;
        end
        ln_table[k] = 2 * acc;
      end
    end
    sym_mode = 0;
    b_rule = 0;
    run_sum = 0;
    sat_seen = 0;
    errors = 0;
    pairs_seen = 0;
    sums_checked = 0;
  endfunction

  function longint unsigned natural_log(logic [31:0] x);
    int e;
    longint unsigned f, scaled, idx, r, lo, hi, diff;
    e = 31;
    while (e > 0 && x[e] == 1'b0) e--;
    f = ({32'b0, x} << (31 - e)) & 64'h7FFF_FFFF;
    scaled = f * SEGMENTS;
    idx = scaled >> 31;
    r = scaled & 64'h7FFF_FFFF;
    lo = ln_table[idx];
    hi = ln_table[idx + 1];
    diff = (hi > lo) ? hi - lo : 0;
    return longint'(e) * LN2_FIX + lo + ((diff * r) >> 31);
  endfunction

  function longint weighted_log_ratio(logic [31:0] x, logic [31:0] y);
    longint unsigned lx, ly, d, hi, lo, mag;
    bit neg;
    lx = natural_log(x);
    ly = natural_log(y);
    neg = lx < ly;
    d = neg ? ly - lx : lx - ly;
    hi = d * {48'b0, x[31:16]};
    lo = d * {48'b0, x[15:0]};
    mag = (hi >> 14) + ((((hi & 64'h3FFF) << 16) + lo) >> 30);
    return neg ? -longint'(mag) : longint'(mag);
  endfunction

  function longint one_direction(logic [31:0] x, logic [31:0] y);
    longint t;
    t = 0;
    if (b_rule && y == 0) return 0;
    if (x != 0 && y != 0) t = weighted_log_ratio(x, y);
    return t + longint'({32'b0, y}) - longint'({32'b0, x});
  endfunction

  function void add_saturating(longint t);
    longint s;
    s = run_sum;
    if (t > 0 && s > 64'sh7FFF_FFFF_FFFF_FFFF - t) begin
      run_sum = 64'sh7FFF_FFFF_FFFF_FFFF;
      sat_seen = 1;
    end else if (t < 0 && s < 64'sh8000_0000_0000_0000 - t) begin
      run_sum = 64'sh8000_0000_0000_0000;
      sat_seen = 1;
    end else begin
      run_sum = s + t;
    end
  endfunction

  function void note_pair(logic [31:0] a, logic [31:0] b, logic last);
    sum_result_t res;
    pairs_seen++;
    add_saturating(one_direction(a, b));
    if (sym_mode) add_saturating(one_direction(b, a));
    if (last) begin
      res.divergence = sym_mode ? (run_sum >>> 1) : run_sum;
      res.overflowed = sat_seen;
      pending_sums.push_back(res);
      run_sum = 0;
      sat_seen = 0;
    end
  endfunction

  function void check_sum(logic signed [63:0] divergence, logic overflowed);
    sum_result_t exp_res;
    if (pending_sums.size() == 0) begin
      $error("unexpected result beat: divergence %0d", divergence);
      errors++;
      return;
    end
    exp_res = pending_sums.pop_front();
    sums_checked++;
    if (divergence !== exp_res.divergence) begin
      $error("divergence: expected %0d, got %0d", exp_res.divergence, divergence);
      errors++;
    end
    if (overflowed !== exp_res.overflowed) begin
      $error("overflowed: expected %0b, got %0b", exp_res.overflowed, overflowed);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DRAIN_CYCLES = 300;
  localparam longint CYCLE_LIMIT = 2_000_000;

  logic                               clk_i;
  logic                               rst_ni;
  logic                               cfg_we_i;
  logic [gkld_pkg::CFG_IDX_W-1:0]     cfg_index_i;
  logic                               cfg_wdata_i;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [31:0]                        a_value_i;
  logic [31:0]                        b_value_i;
  logic                               last_pair_i;
  logic                               out_valid_o;
  logic                               out_ready_i;
  logic signed [63:0]                 divergence_o;
  logic                               overflowed_o;

  divergence_scoreboard sb;
  bit      steady;
  longint  cycles;

  generalized_kl_divergence_top dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_wdata_i,
    .in_valid_i, .in_ready_o, .a_value_i, .b_value_i, .last_pair_i,
    .out_valid_o, .out_ready_i, .divergence_o, .overflowed_o
  );

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(negedge clk_i) begin
    out_ready_i <= steady ? 1'b1 : ($urandom_range(99) >= 28);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) sb.check_sum(divergence_o, overflowed_o);
  end

  task automatic send_pair(logic [31:0] a, logic [31:0] b, logic last);
    @(negedge clk_i);
    if (!steady && $urandom_range(99) < 28) begin
      in_valid_i = 0;
      repeat ($urandom_range(4, 1)) @(negedge clk_i);
    end
    in_valid_i = 1;
    a_value_i = a;
    b_value_i = b;
    last_pair_i = last;
    do @(posedge clk_i); while (!in_ready_o);
    sb.note_pair(a, b, last);
  endtask

  task automatic wait_idle();
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.pending_sums.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [gkld_pkg::CFG_IDX_W-1:0] index, logic value);
    @(negedge clk_i);
    cfg_we_i = 1;
    cfg_index_i = index;
    cfg_wdata_i = value;
    if (index == gkld_pkg::REG_SYMMETRIC_MODE) sb.sym_mode = value;
    else sb.b_rule = value;
    @(negedge clk_i);
    cfg_we_i = 0;
  endtask

  function automatic logic [31:0] pick_value();
    case ($urandom_range(9))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2: return $urandom_range(32'hFFFF, 1);
      3: return $urandom_range(32'h0001_8000, 32'h0000_8000);
      default: return $urandom;
    endcase
  endfunction

  task automatic run_random(int count);
    int left;
    int len;
    left = count;
    while (left > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(60, 20) : $urandom_range(12, 1);
      if (len > left) len = left;
      for (int i = 0; i < len; i++) send_pair(pick_value(), pick_value(), i == len - 1);
      left -= len;
    end
  endtask

  task automatic run_directed();
    send_pair(32'h0, 32'h0, 1);
    send_pair(32'h0, 32'hFFFF_FFFF, 0);
    send_pair(32'hFFFF_FFFF, 32'h0, 1);
    send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
    send_pair(32'h1, 32'hFFFF_FFFF, 0);
    send_pair(32'hFFFF_FFFF, 32'h1, 1);
    send_pair(32'h0001_0000, 32'h0002_0000, 0);
    send_pair(32'h0003_0000, 32'h0000_4000, 1);
  endtask

  initial begin
    bit [1:0] modes [5] = '{2'b00, 2'b01, 2'b10, 2'b11, 2'b00};
    sb = new();
    cycles = 0;
    steady = 0;
    rst_ni = 0;
    cfg_we_i = 0;
    cfg_index_i = gkld_pkg::REG_SYMMETRIC_MODE;
    cfg_wdata_i = 0;
    in_valid_i = 0;
    a_value_i = 0;
    b_value_i = 0;
    last_pair_i = 0;
    out_ready_i = 1;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1;
    foreach (modes[m]) begin
      if (m != 0) begin
        wait_idle();
        write_reg(gkld_pkg::REG_SYMMETRIC_MODE, modes[m][1]);
        write_reg(gkld_pkg::REG_POSITIVE_B_RULE, modes[m][0]);
      end
      run_directed();
      if (m == 2) begin
        steady = 1;
        run_random(150);
        steady = 0;
      end
      run_random(m == 4 ? 250 : 400);
    end
    @(negedge clk_i);
    in_valid_i = 0;
    while (sb.pending_sums.size() != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
    $display("Covered %0d element pairs and %0d checked sums across both rules,",
             sb.pairs_seen, sb.sums_checked);
    $display("with and without symmetric mode, under random gaps and back-pressure.");
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end
endmodule
